/* design/sparse_rows_to_sliced_ellpack_macros.svh */
// Assertion macros used by the converter's top-level RTL file.
`ifndef SPARSE_ROWS_TO_SLICED_ELLPACK_MACROS_SVH
`define SPARSE_ROWS_TO_SLICED_ELLPACK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SR2SELL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SR2SELL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sr2sell_pkg.sv */
// Package with the item types and default sizes of the SELL-C converter.
`timescale 1ns / 1ps

package sr2sell_pkg;

  localparam int SLICE_HEIGHT = 4;
  localparam int MAX_ROW_LEN  = 16;

  localparam int ROW_W    = 24;
  localparam int COL_W    = 24;
  localparam int VAL_W    = 64;
  localparam int OFS_W    = 32;
  localparam int SLICE_W  = 22;
  localparam int SWIDTH_W = 5;

  typedef struct packed {
    logic             opcode;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic [VAL_W-1:0] value_bits;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]    out_value_bits;
    logic [COL_W-1:0]    out_column;
    logic [OFS_W-1:0]    entry_offset;
    logic [SLICE_W-1:0]  slice_number;
    logic [SWIDTH_W-1:0] slice_width;
    logic                slice_end;
    logic                overflow;
  } out_item_t;

endpackage

/* design/sr2sell_chan_if.sv */
// Valid/ready channel interface carrying one item per handshake.
`timescale 1ns / 1ps

interface sr2sell_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

/* design/sr2sell_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sr2sell_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sparse_rows_to_sliced_ellpack.sv */
// Top level of the sparse-row to SELL-C slice converter.
`timescale 1ns / 1ps
`include "sparse_rows_to_sliced_ellpack_macros.svh"

// Nonzero entries come in on in_items in ascending row order and are kept in
// one RAM that holds SLICE_HEIGHT row buffers of MAX_ROW_LEN value/column pairs.
// A nonzero entry that stays in the current slice goes through a reciprocal
// multiply for the slice number, the row remainder, then the row count update and
// the RAM write. An entry that opens a new slice, or a flush item, first drains the
// buffered slice column-major, one result item at a time by a RAM read, then a load
// of the output register, which waits while the sink stalls. A waiting result sits
// in the output register, so the next item is taken while it waits. Entries beyond
// MAX_ROW_LEN in a row are dropped and set the sticky overflow bit.
module sparse_rows_to_sliced_ellpack #(
  parameter int SLICE_HEIGHT = sr2sell_pkg::SLICE_HEIGHT,
  parameter int MAX_ROW_LEN  = sr2sell_pkg::MAX_ROW_LEN
) (
  input logic            clk,
  input logic            rst,
  sr2sell_chan_if.sink   in_items,
  sr2sell_chan_if.source out_items
);

  localparam int ROW_W     = sr2sell_pkg::ROW_W;
  localparam int COL_W     = sr2sell_pkg::COL_W;
  localparam int VAL_W     = sr2sell_pkg::VAL_W;
  localparam int OFS_W     = sr2sell_pkg::OFS_W;
  localparam int SLICE_W   = sr2sell_pkg::SLICE_W;
  localparam int SWIDTH_W  = sr2sell_pkg::SWIDTH_W;
  localparam int LG_H      = $clog2(SLICE_HEIGHT);
  localparam int RW        = (SLICE_HEIGHT > 1) ? LG_H : 1;
  localparam int DW        = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int CW        = $clog2(MAX_ROW_LEN + 1);
  localparam int AW        = RW + DW;
  localparam int DEPTH     = 1 << AW;
  localparam int MEM_W     = VAL_W + COL_W;
  localparam int DIV_SHIFT = ROW_W + LG_H;
  localparam int RCW       = ROW_W + 1;
  localparam int PW        = ROW_W + RCW;
  localparam longint RECIP = ((64'd1 << DIV_SHIFT) + SLICE_HEIGHT - 1) / SLICE_HEIGHT;
  localparam logic [RCW-1:0] RECIP_C = RCW'(RECIP);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_REM   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_LD    = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;

  logic [2:0]         state;
  logic               op_reg;
  logic [ROW_W-1:0]   row_reg;
  logic [COL_W-1:0]   col_reg;
  logic [VAL_W-1:0]   val_reg;
  logic [ROW_W-1:0]   quot;
  logic [RW-1:0]      row_sel;
  logic [CW-1:0]      counts [SLICE_HEIGHT];
  logic [CW-1:0]      width_reg;
  logic [SLICE_W-1:0] cur_slice;
  logic [OFS_W-1:0]   run_ofs;
  logic               ovf;
  logic [DW-1:0]      d_cnt;
  logic [RW-1:0]      r_cnt;
  logic               pad_reg;
  logic               last_reg;
  logic               out_valid;
  sr2sell_pkg::out_item_t out_data;

  logic [PW-1:0]      quot_prod;
  logic [ROW_W-1:0]   quot_h;
  logic [ROW_W-1:0]   rem_full;
  logic [SLICE_W-1:0] slice_num;
  logic               drain_now;
  logic [RW-1:0]      cnt_idx;
  logic [CW-1:0]      cnt_rd;
  logic [CW-1:0]      cnt_inc;
  logic               out_free;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [MEM_W-1:0]   ram_rdata;

  assign quot_prod = {{RCW{1'b0}}, row_reg} * {{ROW_W{1'b0}}, RECIP_C};
  assign quot_h    = ROW_W'(quot * ROW_W'(SLICE_HEIGHT));
  assign rem_full  = row_reg - quot_h;
  assign slice_num = quot[SLICE_W-1:0];
  assign drain_now = (op_reg || (slice_num != cur_slice)) && (width_reg != '0);

  assign cnt_idx   = (state == ST_WRITE) ? row_sel : r_cnt;
  assign cnt_rd    = counts[cnt_idx];
  assign cnt_inc   = cnt_rd + CW'(1);
  assign out_free  = !out_valid || out_items.ready;

  assign ram_we    = (state == ST_WRITE) && (cnt_rd < CW'(MAX_ROW_LEN));
  assign ram_waddr = {row_sel, cnt_rd[DW-1:0]};
  assign ram_re    = (state == ST_RD);
  assign ram_raddr = {r_cnt, d_cnt};

  assign in_items.ready  = (state == ST_IDLE);
  assign out_items.valid = out_valid;
  assign out_items.data  = out_data;

  sr2sell_ram #(
    .WIDTH(MEM_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({val_reg, col_reg}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      width_reg <= '0;
      cur_slice <= '0;
      run_ofs   <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      d_cnt     <= '0;
      r_cnt     <= '0;
      for (int i = 0; i < SLICE_HEIGHT; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (state == ST_LD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_items.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_items.valid) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          state <= ST_REM;
        end
        ST_REM: begin
          d_cnt <= '0;
          r_cnt <= '0;
          if (drain_now) begin
            state <= ST_RD;
          end else if (op_reg) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_WRITE;
          end
        end
        ST_RD: begin
          state <= ST_LD;
        end
        ST_LD: begin
          if (out_free) begin
            run_ofs   <= run_ofs + OFS_W'(1);
            if (last_reg) begin
              width_reg <= '0;
              for (int i = 0; i < SLICE_HEIGHT; i++) begin
                counts[i] <= '0;
              end
              state <= op_reg ? ST_IDLE : ST_WRITE;
            end else begin
              if (r_cnt == RW'(SLICE_HEIGHT - 1)) begin
                r_cnt <= '0;
                d_cnt <= d_cnt + DW'(1);
              end else begin
                r_cnt <= r_cnt + RW'(1);
              end
              state <= ST_RD;
            end
          end
        end
        ST_WRITE: begin
          cur_slice <= slice_num;
          if (ram_we) begin
            counts[row_sel] <= cnt_inc;
            if (cnt_inc > width_reg) begin
              width_reg <= cnt_inc;
            end
          end else begin
            ovf <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_items.valid) begin
      op_reg  <= in_items.data.opcode;
      row_reg <= in_items.data.row_index;
      col_reg <= in_items.data.column_index;
      val_reg <= in_items.data.value_bits;
    end
    if (state == ST_DIV) begin
      quot <= ROW_W'(quot_prod >> DIV_SHIFT);
    end
    if (state == ST_REM) begin
      row_sel <= rem_full[RW-1:0];
    end
    if (state == ST_RD) begin
      pad_reg  <= (CW'(d_cnt) >= cnt_rd);
      last_reg <= (CW'(d_cnt) == width_reg - CW'(1)) && (r_cnt == RW'(SLICE_HEIGHT - 1));
    end
    if (state == ST_LD && out_free) begin
      out_data.out_value_bits <= pad_reg ? '0 : ram_rdata[MEM_W-1:COL_W];
      out_data.out_column     <= pad_reg ? '0 : ram_rdata[COL_W-1:0];
      out_data.entry_offset   <= run_ofs;
      out_data.slice_number   <= cur_slice;
      out_data.slice_width    <= SWIDTH_W'(width_reg);
      out_data.slice_end      <= last_reg;
      out_data.overflow       <= ovf;
    end
  end

  `SR2SELL_ASSERT_NEXT(a_accept_starts_div, in_items.valid && in_items.ready, state == ST_DIV, "Accepted item did not start the slice computation.")
  `SR2SELL_ASSERT_IMP(a_count_within_width, state == ST_RD || state == ST_WRITE, cnt_rd <= width_reg, "Row count exceeds the slice width.")
  `SR2SELL_ASSERT_NEXT(a_overflow_sticky, ovf, ovf, "Overflow flag cleared outside reset.")
  `SR2SELL_ASSERT_NEXT(a_slice_end_clears, state == ST_LD && out_free && last_reg, width_reg == '0 && out_valid, "Slice end did not clear the buffered slice.")

endmodule

/* sim/sparse_rows_to_sliced_ellpack_tb.sv */
// Self-checking testbench of the sparse-row to SELL-C slice converter.
`timescale 1ns / 1ps

module sparse_rows_to_sliced_ellpack_tb;

  localparam int SLICE_HEIGHT = sr2sell_pkg::SLICE_HEIGHT;
  localparam int MAX_ROW_LEN  = sr2sell_pkg::MAX_ROW_LEN;
  localparam int ROW_W        = sr2sell_pkg::ROW_W;
  localparam int COL_W        = sr2sell_pkg::COL_W;
  localparam int VAL_W        = sr2sell_pkg::VAL_W;
  localparam int OFS_W        = sr2sell_pkg::OFS_W;
  localparam int SLICE_W      = sr2sell_pkg::SLICE_W;
  localparam int SWIDTH_W     = sr2sell_pkg::SWIDTH_W;

  typedef sr2sell_pkg::in_item_t  in_item_t;
  typedef sr2sell_pkg::out_item_t out_item_t;

  localparam logic OP_ENTRY = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam int RANDOM_ITEMS = 340;
  localparam int LIMIT_CYCLES = 600000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    int        typed_count;
    out_item_t typed_first;
  } plan_row_t;

  logic clk;
  logic rst;

  sr2sell_chan_if #(.payload_t(in_item_t)) in_ch ();
  sr2sell_chan_if #(.payload_t(out_item_t)) out_ch ();

  sparse_rows_to_sliced_ellpack DUT (
    .clk(clk),
    .rst(rst),
    .in_items(in_ch),
    .out_items(out_ch)
  );

  logic [VAL_W-1:0]    slot_value [SLICE_HEIGHT][MAX_ROW_LEN];
  logic [COL_W-1:0]    slot_column [SLICE_HEIGHT][MAX_ROW_LEN];
  logic [SWIDTH_W-1:0] row_fill [SLICE_HEIGHT];
  logic [SLICE_W-1:0]  open_slice;
  logic [OFS_W-1:0]    next_offset;
  logic                dropped_seen;

  out_item_t fresh_results[$];
  out_item_t pending_slice_entries[$];
  plan_row_t directed_plan[$];

  int err_count;
  int cycle_count;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  task automatic drain_buffered_slice();
    int unsigned widest;
    int total;
    int n;
    out_item_t r;
    widest = 0;
    n = 0;
    for (int k = 0; k < SLICE_HEIGHT; k++)
      if (row_fill[k] > widest) widest = row_fill[k];
    if (widest == 0) return;
    total = widest * SLICE_HEIGHT;
    for (int d = 0; d < widest; d++) begin
      for (int k = 0; k < SLICE_HEIGHT; k++) begin
        r.out_value_bits = (d < row_fill[k]) ? slot_value[k][d] : '0;
        r.out_column     = (d < row_fill[k]) ? slot_column[k][d] : '0;
        r.entry_offset   = next_offset;
        r.slice_number   = open_slice;
        r.slice_width    = SWIDTH_W'(widest);
        r.slice_end      = (n == total - 1);
        r.overflow       = dropped_seen;
        fresh_results.push_back(r);
        next_offset = next_offset + OFS_W'(1);
        n++;
      end
    end
    for (int k = 0; k < SLICE_HEIGHT; k++) row_fill[k] = '0;
  endtask

  task automatic convert_item(input in_item_t it);
    logic [SLICE_W-1:0] slc;
    int k;
    if (it.opcode == OP_FLUSH) begin
      drain_buffered_slice();
      return;
    end
    slc = SLICE_W'(it.row_index / SLICE_HEIGHT);
    if (slc != open_slice) drain_buffered_slice();
    open_slice = slc;
    k = it.row_index % SLICE_HEIGHT;
    if (row_fill[k] >= MAX_ROW_LEN) begin
      dropped_seen = 1'b1;
    end else begin
      slot_value[k][row_fill[k]] = it.value_bits;
      slot_column[k][row_fill[k]] = it.column_index;
      row_fill[k] = row_fill[k] + SWIDTH_W'(1);
    end
  endtask

  function automatic in_item_t entry_item(input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col,
                                          input logic [VAL_W-1:0] val);
    in_item_t it;
    it.opcode = OP_ENTRY;
    it.row_index = row;
    it.column_index = col;
    it.value_bits = val;
    return it;
  endfunction

  function automatic in_item_t flush_item();
    in_item_t it;
    it = '0;
    it.opcode = OP_FLUSH;
    return it;
  endfunction

  function automatic out_item_t slice_result(input logic [VAL_W-1:0] val,
                                             input logic [COL_W-1:0] col,
                                             input logic [OFS_W-1:0] ofs,
                                             input logic [SLICE_W-1:0] slc,
                                             input logic [SWIDTH_W-1:0] wid,
                                             input logic eos, input logic ovf);
    out_item_t r;
    r.out_value_bits = val;
    r.out_column = col;
    r.entry_offset = ofs;
    r.slice_number = slc;
    r.slice_width = wid;
    r.slice_end = eos;
    r.overflow = ovf;
    return r;
  endfunction

  function automatic plan_row_t plan_row(input in_item_t it, input int reps, input bit typed,
                                         input int cnt, input out_item_t first);
    plan_row_t p;
    p.item = it;
    p.reps = reps;
    p.typed = typed;
    p.typed_count = cnt;
    p.typed_first = first;
    return p;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input int typed_count,
                           input out_item_t typed_first);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    fresh_results.delete();
    convert_item(it);
    if (typed) begin
      if (fresh_results.size() != typed_count)
        report_mismatch($sformatf("directed item gives %0d results, table says %0d",
                                  fresh_results.size(), typed_count));
      if (typed_count > 0 && fresh_results.size() > 0) fresh_results[0] = typed_first;
    end
    foreach (fresh_results[j]) pending_slice_entries.push_back(fresh_results[j]);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_slice_entries.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.out_value_bits !== want.out_value_bits)
      report_mismatch($sformatf("offset %0d value %h, expected %h", want.entry_offset,
                                got.out_value_bits, want.out_value_bits));
    if (got.out_column !== want.out_column)
      report_mismatch($sformatf("offset %0d column %h, expected %h", want.entry_offset,
                                got.out_column, want.out_column));
    if (got.entry_offset !== want.entry_offset)
      report_mismatch($sformatf("entry offset %0d, expected %0d", got.entry_offset,
                                want.entry_offset));
    if (got.slice_number !== want.slice_number)
      report_mismatch($sformatf("offset %0d slice %h, expected %h", want.entry_offset,
                                got.slice_number, want.slice_number));
    if (got.slice_width !== want.slice_width)
      report_mismatch($sformatf("offset %0d width %0d, expected %0d", want.entry_offset,
                                got.slice_width, want.slice_width));
    if (got.slice_end !== want.slice_end)
      report_mismatch($sformatf("offset %0d slice end %b, expected %b", want.entry_offset,
                                got.slice_end, want.slice_end));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("offset %0d overflow %b, expected %b", want.entry_offset,
                                got.overflow, want.overflow));
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_slice_entries.size() == 0)
          report_mismatch($sformatf("result at offset %0d with nothing expected",
                                    out_ch.data.entry_offset));
        else
          check_result(out_ch.data, pending_slice_entries.pop_front());
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else begin
        case ((cycle_count / 128) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ((cycle_count % 7) < 3);
        endcase
      end
    end
  end

  initial begin
    logic [ROW_W-1:0] cursor_row;
    in_item_t it;
    int heavy_left;
    int p;
    err_count = 0;
    burst_left = 4;
    heavy_left = 0;
    cursor_row = '0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int k = 0; k < SLICE_HEIGHT; k++) begin
      row_fill[k] = '0;
      for (int d = 0; d < MAX_ROW_LEN; d++) begin
        slot_value[k][d] = '0;
        slot_column[k][d] = '0;
      end
    end
    open_slice = '0;
    next_offset = '0;
    dropped_seen = 1'b0;

    directed_plan.push_back(plan_row(flush_item(), 1, 1'b1, 0, '0));
    directed_plan.push_back(plan_row(entry_item(24'd0, 24'hFFFFFF, '1), 1, 1'b1, 0, '0));
    directed_plan.push_back(plan_row(entry_item(24'd3, 24'd0, '0), 1, 1'b1, 0, '0));
    directed_plan.push_back(plan_row(flush_item(), 1, 1'b1, 4,
                            slice_result('1, 24'hFFFFFF, 32'd0, 22'd0, 5'd1, 1'b0, 1'b0)));
    directed_plan.push_back(plan_row(flush_item(), 1, 1'b1, 0, '0));
    directed_plan.push_back(plan_row(entry_item(24'hFFFFFF, 24'h123456, 64'd1),
                            1, 1'b1, 0, '0));
    directed_plan.push_back(plan_row(entry_item(24'd0, 24'd0, 64'h8000_0000_0000_0001),
                            MAX_ROW_LEN + 1, 1'b1, 4,
                            slice_result('0, '0, 32'd4, 22'h3FFFFF, 5'd1, 1'b0, 1'b0)));
    directed_plan.push_back(plan_row(entry_item(24'd2, 24'hABCDEF, 64'h5555_AAAA_5555_AAAA),
                            1, 1'b0, 0, '0));
    directed_plan.push_back(plan_row(flush_item(), 1, 1'b1, SLICE_HEIGHT * MAX_ROW_LEN,
                            slice_result(64'h8000_0000_0000_0001, '0, 32'd8, 22'd0,
                                         5'd16, 1'b0, 1'b1)));
    directed_plan.push_back(plan_row(entry_item(24'd40, 24'd1, 64'h0123_4567_89AB_CDEF),
                            1, 1'b0, 0, '0));
    directed_plan.push_back(plan_row(entry_item(24'd8, 24'd2, 64'hFEDC_BA98_7654_3210),
                            1, 1'b0, 0, '0));
    directed_plan.push_back(plan_row(entry_item(24'd9, 24'h800000, 64'hDEAD_BEEF_0000_0001),
                            3, 1'b0, 0, '0));
    directed_plan.push_back(plan_row(entry_item(24'd11, 24'h7FFFFF, 64'h7FF0_0000_0000_0000),
                            1, 1'b0, 0, '0));
    directed_plan.push_back(plan_row(entry_item(24'd4, 24'h000100, 64'h3FF0_0000_0000_0000),
                            1, 1'b0, 0, '0));
    directed_plan.push_back(plan_row(flush_item(), 1, 1'b0, 0, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      for (int k = 0; k < directed_plan[i].reps; k++) begin
        it = directed_plan[i].item;
        it.column_index = it.column_index + COL_W'(k);
        send_item(it, directed_plan[i].typed && k == 0, directed_plan[i].typed_count,
                  directed_plan[i].typed_first);
      end
    end
    hold_until_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      p = $urandom_range(0, 99);
      if (i == RANDOM_ITEMS - 1 || (heavy_left == 0 && p < 6)) begin
        it = flush_item();
        it.row_index = ROW_W'($urandom);
        it.column_index = COL_W'($urandom);
        it.value_bits = {$urandom, $urandom};
      end else begin
        if (heavy_left > 0) begin
          heavy_left--;
        end else if (p < 8) begin
          heavy_left = $urandom_range(14, 20);
        end else if (p < 14) begin
          cursor_row = ROW_W'($urandom);
        end else if (p < 40) begin
          cursor_row = ROW_W'((cursor_row / SLICE_HEIGHT + $urandom_range(1, 3)) *
                              SLICE_HEIGHT + $urandom_range(0, SLICE_HEIGHT - 1));
        end else begin
          cursor_row = ROW_W'((cursor_row / SLICE_HEIGHT) * SLICE_HEIGHT +
                              $urandom_range(0, SLICE_HEIGHT - 1));
        end
        it = entry_item(cursor_row, COL_W'($urandom), {$urandom, $urandom});
      end
      send_item(it, 1'b0, 0, '0);
    end

    in_ch.valid <= 1'b0;
    while (pending_slice_entries.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
